/* hdl/lrukv_pkg.sv */
`default_nettype none

package lrukv_pkg;

	// store geometry
	localparam int ENTRIES = 16;
	localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// field widths
	localparam int CAP_W = 5;
	localparam int OCC_W = 5;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request payload
	typedef struct packed {
		logic                    mode;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// response payload
	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
		logic [OCC_W-1:0]        occupancy;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

/* hdl/lrukv_ctrl.sv */
`default_nettype none

module lrukv_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output lrukv_pkg::cmd_t   cmd
);

	typedef enum logic {
		S_IDLE,
		S_UPDATE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   rsp_valid_q;
	logic   commit;

	// update may proceed once the response register is free or being drained
	assign commit      = (state_q == S_UPDATE) && (!rsp_valid_q || rsp_ready);
	assign cmd.capture = req_valid && ready_q;
	assign cmd.commit  = commit;
	assign req_ready   = ready_q;
	assign rsp_valid   = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= S_UPDATE;
						ready_q <= 1'b0;
					end
				end
				S_UPDATE: begin
					if (commit) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/lrukv_datapath.sv */
`default_nettype none

module lrukv_datapath (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [lrukv_pkg::CAP_W-1:0]      cfg_wdata,
	input  lrukv_pkg::req_t                 req,
	input  lrukv_pkg::cmd_t                 cmd,
	output lrukv_pkg::rsp_t                 rsp
);

	localparam int N  = lrukv_pkg::ENTRIES;
	localparam int RW = lrukv_pkg::RANK_W;
	localparam int CW = lrukv_pkg::CNT_W;
	localparam int AW = lrukv_pkg::VAL_W;
	localparam int KW = lrukv_pkg::KEY_W;
	localparam int PW = lrukv_pkg::CAP_W;
	localparam int XW = (CW > PW) ? CW : PW;

	// entry storage
	logic [KW-1:0]    key_q [N];
	logic [AW-1:0]    val_q [N];
	logic [N-1:0]     valid_q;
	logic [RW-1:0]    rank_q [N];
	logic [CW-1:0]    count_q;
	logic [PW-1:0]    cap_q;

	// captured request and match vector
	logic             mode_s1;
	logic [KW-1:0]    key_s1;
	logic [AW-1:0]    value_s1;
	logic [N-1:0]     match_s1;

	lrukv_pkg::rsp_t  rsp_q;

	logic [N-1:0]     match_now;
	logic             hit_w;
	logic [RW-1:0]    hit_rank;
	logic [AW-1:0]    hit_val;
	logic             evict;
	logic [CW-1:0]    last;
	logic [N-1:0]     oldest;
	logic [N-1:0]     vacate;
	logic [N-1:0]     keep;
	logic [N-1:0]     free;
	logic [N-1:0]     lowest;
	logic             insert_w;
	logic [CW-1:0]    count_next;

	// parallel key compare against the live request
	always_comb begin
		for (int i = 0; i < N; i++) begin
			match_now[i] = valid_q[i] && (key_q[i] == req.key);
		end
	end

	always_comb begin
		hit_rank = '0;
		hit_val  = '0;
		for (int i = 0; i < N; i++) begin
			if (match_s1[i]) begin
				hit_rank = hit_rank | rank_q[i];
				hit_val  = hit_val | val_q[i];
			end
		end
		hit_w = |match_s1;

		// full against the effective capacity (zero means one, saturates at depth)
		if (cap_q == '0) begin
			evict = (count_q != '0);
		end else begin
			evict = (count_q >= CW'(N)) || (XW'(count_q) >= XW'(cap_q));
		end

		// ranks form a permutation, so the oldest holds rank count-1
		last = count_q - 1'b1;
		for (int i = 0; i < N; i++) begin
			oldest[i] = valid_q[i] && (CW'(rank_q[i]) == last);
		end
		vacate   = evict ? oldest : '0;
		keep     = valid_q & ~vacate;
		free     = ~keep;
		lowest   = free & (~free + 1'b1);
		insert_w = |lowest;

		if (hit_w || !mode_s1) begin
			count_next = count_q;
		end else begin
			count_next = count_q - CW'(|vacate) + CW'(insert_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			cap_q   <= lrukv_pkg::CAP_RESET;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				count_q <= count_next;
				if (hit_w) begin
					for (int i = 0; i < N; i++) begin
						if (match_s1[i]) begin
							rank_q[i] <= '0;
						end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
				end else if (mode_s1) begin
					for (int i = 0; i < N; i++) begin
						if (lowest[i]) begin
							valid_q[i] <= 1'b1;
							rank_q[i]  <= '0;
						end else if (keep[i]) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end else if (vacate[i]) begin
							valid_q[i] <= 1'b0;
							rank_q[i]  <= '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_s1  <= req.mode;
			key_s1   <= req.key;
			value_s1 <= req.value;
			match_s1 <= match_now;
		end
		if (cmd.commit) begin
			rsp_q.hit        <= hit_w;
			rsp_q.read_value <= hit_w ? hit_val : '0;
			rsp_q.occupancy  <= lrukv_pkg::OCC_W'(count_next);
			if (!hit_w && mode_s1) begin
				for (int i = 0; i < N; i++) begin
					if (lowest[i]) begin
						key_q[i] <= key_s1;
						val_q[i] <= value_s1;
					end
				end
			end
		end
	end

	assign rsp = rsp_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == count_q)
		else $error("entry count disagrees with valid bits");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("entry count above depth");

	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && hit_w |=> count_q == $past(count_q))
		else $error("hit changed occupancy");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !hit_w && mode_s1 && !evict |=> count_q == $past(count_q) + 1'b1)
		else $error("insert below capacity did not add an entry");

endmodule

`default_nettype wire

/* hdl/lru_key_value_cache.sv */
// a transfer is captured in the idle state and committed to the response
// register in the update state; no new request is taken before that commit
// the update state waits while an earlier response has not yet been taken
// reset: asynchronous active low; store empty, capacity 16, no response pending
`default_nettype none

module lru_key_value_cache (
	input  wire                         clk,
	input  wire                         arst_n,
	// capacity register write
	input  wire                         cfg_we,
	input  wire [lrukv_pkg::CAP_W-1:0]  cfg_wdata,
	// request channel
	input  wire                         req_valid,
	output logic                        req_ready,
	input  lrukv_pkg::req_t             req,
	// response channel
	output logic                        rsp_valid,
	input  wire                         rsp_ready,
	output lrukv_pkg::rsp_t             rsp
);

	// commands from the sequencer to the store
	lrukv_pkg::cmd_t cmd;

	// sequencer: idle accepts a transfer, update commits it into the
	// response register once that register is free or draining, so a new
	// request is taken while the previous response still waits
	lrukv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// store: key compare across all entries on the incoming request at
	// transfer, then in the update cycle rank update and, for a put that misses, eviction
	// of the least recent entry when full and fill of the lowest free slot
	lrukv_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

/* tb/lru_key_value_cache_test.sv */
`default_nettype none

module lru_key_value_cache_test;

	// request modes
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// cycles without any transfer or register write before the run is abandoned
	localparam int STALL_LIMIT = 4000;
	// long receiver hold-off used to fill the block up
	localparam int LONG_HOLD = 300;
	// cycles allowed after the last response before anything else happens
	localparam int SETTLE_CYCLES = 4;
	// random phases and items per phase
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 190;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        cfg_we = 1'b0;
	logic [lrukv_pkg::CAP_W-1:0] cfg_wdata = '0;

	logic            req_valid = 1'b0;
	logic            req_ready;
	lrukv_pkg::req_t req = '0;

	logic            rsp_valid;
	logic            rsp_ready = 1'b0;
	lrukv_pkg::rsp_t rsp;

	// pending responses, oldest first
	lrukv_pkg::rsp_t expected_rsp[$];

	// shadow copy of the store, kept in step with every accepted request
	logic [lrukv_pkg::KEY_W-1:0] cached_key[lrukv_pkg::ENTRIES];
	logic [lrukv_pkg::VAL_W-1:0] cached_value[lrukv_pkg::ENTRIES];
	bit                          cached_used[lrukv_pkg::ENTRIES];
	int                          cached_age[lrukv_pkg::ENTRIES];
	int                          cached_count;
	logic [lrukv_pkg::CAP_W-1:0] cached_cap;

	// keys that random traffic keeps returning to, so hits and evictions happen
	logic [lrukv_pkg::KEY_W-1:0] key_pool[$];

	int  mismatches = 0;
	int  stall_cycles = 0;
	bit  idle_on = 1'b1;
	int  rsp_hold = 0;

	lru_key_value_cache u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 4 time unit clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// expected response for one request; updates the shadow store as the block should
	function automatic lrukv_pkg::rsp_t cache_predict(input lrukv_pkg::req_t item);
		lrukv_pkg::rsp_t r;
		int   slot;
		int   oldest;
		int   free_slot;
		int   limit;
		int   age_hit;
		r = '0;
		slot = -1;
		for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
			if (slot < 0 && cached_used[i] && cached_key[i] == item.key)
				slot = i;
		end
		if (slot >= 0) begin
			// hit: report the stored value and make the entry most recent
			r.hit = 1'b1;
			r.read_value = cached_value[slot];
			age_hit = cached_age[slot];
			for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
				if (cached_used[i] && i != slot && cached_age[i] < age_hit)
					cached_age[i]++;
			end
			cached_age[slot] = 0;
		end else if (item.mode == MODE_PUT) begin
			// zero capacity acts as one, anything beyond the store saturates
			if (cached_cap == 0)
				limit = 1;
			else if (cached_cap > lrukv_pkg::ENTRIES)
				limit = lrukv_pkg::ENTRIES;
			else
				limit = cached_cap;
			if (cached_count >= limit) begin
				oldest = -1;
				for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
					if (cached_used[i] && (oldest < 0 || cached_age[i] > cached_age[oldest]))
						oldest = i;
				end
				if (oldest >= 0) begin
					cached_used[oldest] = 1'b0;
					cached_age[oldest] = 0;
					if (cached_count > 0)
						cached_count--;
				end
			end
			// new entry goes in the lowest free slot
			free_slot = -1;
			for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
				if (free_slot < 0 && !cached_used[i])
					free_slot = i;
			end
			if (free_slot >= 0) begin
				for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
					if (cached_used[i])
						cached_age[i]++;
				end
				cached_key[free_slot] = item.key;
				cached_value[free_slot] = item.value;
				cached_used[free_slot] = 1'b1;
				cached_age[free_slot] = 0;
				cached_count++;
			end
		end
		r.occupancy = cached_count[lrukv_pkg::OCC_W-1:0];
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
	endtask

	// response checker, sampled on the rising edge
	always @(posedge clk) begin
		lrukv_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				note_mismatch("unexpected response", 32'h0, {31'h0, rsp.hit});
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.hit !== want.hit)
					note_mismatch("hit", {31'h0, want.hit}, {31'h0, rsp.hit});
				if (rsp.read_value !== want.read_value)
					note_mismatch("read_value", want.read_value, rsp.read_value);
				if (rsp.occupancy !== want.occupancy)
					note_mismatch("occupancy", {27'h0, want.occupancy}, {27'h0, rsp.occupancy});
			end
		end
	end

	// watchdog: any transfer or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("** lru_key_value_cache: FAILED **");
				$finish;
			end
		end
	end

	// response sink: random hold-off per transfer, or one long hold when asked
	initial begin : rsp_sink
		int gap;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (rsp_hold > 0)
				gap = rsp_hold;
			else
				gap = idle_on ? $urandom_range(15) : 0;
			rsp_hold = 0;
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	// one request transfer; entered and left on a falling edge
	// valid is left high afterwards so back-to-back transfers need no dip
	task automatic send_request(input logic mode, input logic [lrukv_pkg::KEY_W-1:0] key,
		input logic [lrukv_pkg::VAL_W-1:0] value);
		lrukv_pkg::req_t item;
		int   gap;
		item.mode = mode;
		item.key = key;
		item.value = value;
		gap = idle_on ? $urandom_range(15) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		expected_rsp.push_back(cache_predict(item));
		@(negedge clk);
	endtask

	// drop valid and wait for every outstanding response
	task automatic drain;
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// capacity write, only ever done with the block idle
	task automatic set_capacity(input logic [lrukv_pkg::CAP_W-1:0] cap);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		cached_cap = cap;
	endtask

	task automatic send_random(input int pool_pct);
		logic [lrukv_pkg::KEY_W-1:0] k;
		if (key_pool.size() > 0 && $urandom_range(99) < pool_pct)
			k = key_pool[$urandom_range(key_pool.size() - 1)];
		else
			k = $urandom;
		send_request(1'($urandom_range(1)), k, $urandom);
	endtask

	// tiny capacities while the store is still nearly empty
	task automatic test_small_capacity;
		set_capacity(5'd1);
		send_request(MODE_GET, 32'h0000_0000, 32'h1111_1111);  // empty store
		send_request(MODE_PUT, 32'h0000_00a1, 32'h0000_0001);
		send_request(MODE_PUT, 32'h0000_00a2, 32'h0000_0002);  // evicts the first
		send_request(MODE_GET, 32'h0000_00a1, 32'h0);
		send_request(MODE_GET, 32'h0000_00a2, 32'h0);
		set_capacity(5'd0);
		send_request(MODE_PUT, 32'h0000_00a3, 32'h0000_0003);
		send_request(MODE_GET, 32'h0000_00a3, 32'h0);
		set_capacity(5'd3);
		for (int i = 0; i < 5; i++)
			send_request(MODE_PUT, 32'h0000_00b0 + i, $urandom);
	endtask

	// field extremes, minus-one as a value, refresh on insert, fill and evict
	task automatic test_directed;
		set_capacity(5'd16);
		send_request(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
		send_request(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send_request(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
		send_request(MODE_GET, 32'hffff_ffff, 32'h0);
		send_request(MODE_PUT, 32'h8000_0000, 32'h0000_0005);  // kept, not overwritten
		send_request(MODE_GET, 32'h7fff_ffff, 32'hffff_ffff);
		send_request(MODE_GET, 32'h0000_1234, 32'h0);
		send_request(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
		for (int i = 0; i < 12; i++)
			send_request(MODE_PUT, 32'h0000_0100 + i, 32'h5a5a_0000 + i);
		send_request(MODE_GET, 32'h8000_0000, 32'h0);
		send_request(MODE_GET, 32'hffff_ffff, 32'h0);
	endtask

	// capacity lowered under the occupancy, then saturated above the store
	task automatic test_capacity_limits;
		set_capacity(5'd0);
		send_request(MODE_PUT, 32'h0000_0c01, 32'h0000_0c01);
		send_request(MODE_PUT, 32'h0000_0c02, 32'h0000_0c02);
		send_request(MODE_GET, 32'h0000_0c01, 32'h0);
		set_capacity(5'd31);
		send_request(MODE_PUT, 32'h0000_0c03, 32'h0000_0c03);
		send_request(MODE_GET, 32'h0000_0c02, 32'h0);
	endtask

	task automatic test_random;
		logic [lrukv_pkg::CAP_W-1:0] cap;
		int                          pool_size;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: cap = 5'd16;
				1: cap = 5'd1;
				2: cap = 5'd0;
				3: cap = 5'd31;
				4: cap = 5'd17;
				5: cap = 5'($urandom_range(2, 15));
				default: cap = 5'($urandom_range(31));
			endcase
			set_capacity(cap);
			// one phase runs flat out on both sides
			idle_on = (p != 3);
			key_pool.delete();
			pool_size = $urandom_range(2, 40);
			for (int i = 0; i < pool_size; i++) begin
				case ($urandom_range(9))
					0: key_pool.push_back(32'h0000_0000);
					1: key_pool.push_back(32'hffff_ffff);
					2: key_pool.push_back(32'h8000_0000);
					3: key_pool.push_back(32'h7fff_ffff);
					default: key_pool.push_back($urandom);
				endcase
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random(80);
		end
		idle_on = 1'b1;
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_backpressure;
		drain();
		idle_on = 1'b0;
		rsp_hold = LONG_HOLD;
		for (int i = 0; i < 40; i++)
			send_random(80);
		idle_on = 1'b1;
	endtask

	// sender stops between bursts until every response is back
	task automatic test_sender_pause;
		for (int b = 0; b < 5; b++) begin
			for (int i = 0; i < 10; i++)
				send_random(80);
			drain();
		end
	endtask

	initial begin
		for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
			cached_key[i] = '0;
			cached_value[i] = '0;
			cached_used[i] = 1'b0;
			cached_age[i] = 0;
		end
		cached_count = 0;
		cached_cap = lrukv_pkg::CAP_RESET;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_small_capacity();
		test_directed();
		test_capacity_limits();
		test_random();
		test_backpressure();
		test_sender_pause();

		drain();
		if (mismatches == 0)
			$display("** lru_key_value_cache: PASSED **");
		else
			$display("** lru_key_value_cache: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
